// ----- hw/rtl/bcdd_pkg.sv -----
// ----------------------------------------------------------------------------
// bcdd_pkg
// Shared types, widths and constants of the binary to decimal digits unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bcdd_pkg;

  localparam int VALUE_W        = 31;
  localparam int DIGIT_W        = 4;
  localparam int COUNT_W        = 4;
  // Digits a 31-bit value can have at most.
  localparam int HW_DIGITS      = 10;
  localparam int MAX_DIGITS_DEF = 10;
  localparam int QUEUE_DEPTH_DEF = 2;
  localparam int SHIFT_CNT_W    = $clog2(VALUE_W);

  typedef enum logic [1:0] {
    FRONT_IDLE,
    FRONT_SHIFT,
    FRONT_PUSH
  } front_state_e;

  typedef enum logic {
    BACK_IDLE,
    BACK_EMIT
  } back_state_e;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // Elaboration-time power of ten.
  function automatic logic [63:0] pow10_f(input int n);
    logic [63:0] r;
    r = 64'd1;
    for (int i = 0; i < n; i++) begin
      r = r * 64'd10;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/bcdd_front.sv -----
// ----------------------------------------------------------------------------
// bcdd_front
// Accepts an item, converts it by serial shift-add-3 and classifies the
// digit count, then pushes the packed result into the queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bcdd_front #(
  parameter int LIMIT = 10
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic [bcdd_pkg::VALUE_W-1:0]   value_i,
  input  wire bcdd_pkg::q_status_t            q_status_i,
  output logic                                push_o,
  output logic [bcdd_pkg::COUNT_W-1:0]        push_count_o,
  output logic [LIMIT*bcdd_pkg::DIGIT_W-1:0]  push_bcd_o
);
  import bcdd_pkg::*;

  localparam int          BCD_W     = LIMIT * DIGIT_W;
  localparam logic [63:0] LIMIT_POW = pow10_f(LIMIT);

  front_state_e           state_q, state_d;
  logic [VALUE_W-1:0]     shift_q, shift_d;
  logic [BCD_W-1:0]       bcd_q, bcd_d;
  logic [SHIFT_CNT_W-1:0] cnt_q, cnt_d;
  logic                   ovf_q, ovf_d;
  logic [BCD_W-1:0]       adj;
  logic                   ovf_in;
  logic [COUNT_W-1:0]     count;

  // Value needs more digits than the register keeps: only low digits survive.
  assign ovf_in = (LIMIT < HW_DIGITS) && (64'(value_i) >= LIMIT_POW);

  always_comb begin
    for (int i = 0; i < LIMIT; i++) begin
      if (bcd_q[i*DIGIT_W +: DIGIT_W] >= 4'd5) begin
        adj[i*DIGIT_W +: DIGIT_W] = bcd_q[i*DIGIT_W +: DIGIT_W] + 4'd3;
      end else begin
        adj[i*DIGIT_W +: DIGIT_W] = bcd_q[i*DIGIT_W +: DIGIT_W];
      end
    end
  end

  always_comb begin
    count = COUNT_W'(1);
    for (int i = 1; i < LIMIT; i++) begin
      if (bcd_q[i*DIGIT_W +: DIGIT_W] != 4'd0) begin
        count = COUNT_W'(i + 1);
      end
    end
    if (ovf_q) begin
      count = COUNT_W'(LIMIT);
    end
  end

  assign push_count_o = count;
  assign push_bcd_o   = bcd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FRONT_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    shift_q <= shift_d;
    bcd_q   <= bcd_d;
    cnt_q   <= cnt_d;
    ovf_q   <= ovf_d;
  end

  always_comb begin
    state_d = state_q;
    shift_d = shift_q;
    bcd_d   = bcd_q;
    cnt_d   = cnt_q;
    ovf_d   = ovf_q;
    busy    = 1'b1;
    push_o  = 1'b0;
    unique case (state_q)
      FRONT_IDLE: begin
        busy = 1'b0;
        if (start) begin
          shift_d = value_i;
          bcd_d   = '0;
          cnt_d   = '0;
          ovf_d   = ovf_in;
          state_d = FRONT_SHIFT;
        end
      end
      FRONT_SHIFT: begin
        bcd_d   = {adj[BCD_W-2:0], shift_q[VALUE_W-1]};
        shift_d = {shift_q[VALUE_W-2:0], 1'b0};
        cnt_d   = cnt_q + SHIFT_CNT_W'(1);
        if (cnt_q == SHIFT_CNT_W'(VALUE_W - 1)) begin
          state_d = FRONT_PUSH;
        end
      end
      FRONT_PUSH: begin
        if (!q_status_i.full) begin
          push_o  = 1'b1;
          state_d = FRONT_IDLE;
        end
      end
      default: state_d = FRONT_IDLE;
    endcase
  end

  a_push_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> !q_status_i.full)
    else $error("front pushed into a full queue");
  a_accept_shifts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!busy && start) |=> (state_q == FRONT_SHIFT && cnt_q == '0))
    else $error("accepted item did not start conversion");
  a_push_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |=> !busy)
    else $error("front not idle after push");

endmodule

`default_nettype wire

// ----- hw/rtl/bcdd_queue.sv -----
// ----------------------------------------------------------------------------
// bcdd_queue
// Small register FIFO between the converter and the digit emitter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bcdd_queue #(
  parameter int WIDTH = 44,
  parameter int DEPTH = 2
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire logic [WIDTH-1:0]  din_i,
  input  wire logic              pop_i,
  output logic [WIDTH-1:0]       dout_o,
  output bcdd_pkg::q_status_t    status_o
);
  import bcdd_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FILL_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0]  mem_q [DEPTH];
  logic [PTR_W-1:0]  wr_q, rd_q;
  logic [FILL_W-1:0] fill_q;

  function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign dout_o         = mem_q[rd_q];
  assign status_o.full  = (fill_q == FILL_W'(DEPTH));
  assign status_o.empty = (fill_q == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q   <= '0;
      rd_q   <= '0;
      fill_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wrap_inc(wr_q);
      end
      if (pop_i) begin
        rd_q <= wrap_inc(rd_q);
      end
      if (push_i && !pop_i) begin
        fill_q <= fill_q + FILL_W'(1);
      end else if (pop_i && !push_i) begin
        fill_q <= fill_q - FILL_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= din_i;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/bcdd_back.sv -----
// ----------------------------------------------------------------------------
// bcdd_back
// Takes converted items from the queue and sends their digits out, most
// significant first, one per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bcdd_back #(
  parameter int LIMIT = 10
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire bcdd_pkg::q_status_t            q_status_i,
  input  wire logic [bcdd_pkg::COUNT_W-1:0]   q_count_i,
  input  wire logic [LIMIT*bcdd_pkg::DIGIT_W-1:0] q_bcd_i,
  output logic                                pop_o,
  output logic                                result_valid_o,
  output logic [bcdd_pkg::DIGIT_W-1:0]        digit_o,
  output logic [bcdd_pkg::COUNT_W-1:0]        digit_count_o,
  output logic                                last_o
);
  import bcdd_pkg::*;

  localparam int BCD_W = LIMIT * DIGIT_W;
  localparam int IDX_W = (LIMIT > 1) ? $clog2(LIMIT) : 1;

  back_state_e        state_q, state_d;
  logic [BCD_W-1:0]   bcd_q, bcd_d;
  logic [COUNT_W-1:0] count_q, count_d;
  logic [COUNT_W-1:0] idx_q, idx_d;
  logic [IDX_W-1:0]   idx_sel;

  assign idx_sel = idx_q[IDX_W-1:0];

  always_comb begin
    digit_o = '0;
    for (int i = 0; i < LIMIT; i++) begin
      if (idx_sel == IDX_W'(i)) begin
        digit_o = bcd_q[i*DIGIT_W +: DIGIT_W];
      end
    end
  end

  assign digit_count_o = count_q;
  assign last_o        = result_valid_o && (idx_q == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BACK_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bcd_q   <= bcd_d;
    count_q <= count_d;
    idx_q   <= idx_d;
  end

  always_comb begin
    state_d        = state_q;
    bcd_d          = bcd_q;
    count_d        = count_q;
    idx_d          = idx_q;
    pop_o          = 1'b0;
    result_valid_o = 1'b0;
    unique case (state_q)
      BACK_IDLE: begin
        if (!q_status_i.empty) begin
          pop_o   = 1'b1;
          bcd_d   = q_bcd_i;
          count_d = q_count_i;
          idx_d   = q_count_i - COUNT_W'(1);
          state_d = BACK_EMIT;
        end
      end
      BACK_EMIT: begin
        result_valid_o = 1'b1;
        if (idx_q == '0) begin
          state_d = BACK_IDLE;
        end else begin
          idx_d = idx_q - COUNT_W'(1);
        end
      end
      default: state_d = BACK_IDLE;
    endcase
  end

  a_digit_decimal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (digit_o <= 4'd9))
    else $error("digit out of decimal range");
  a_run_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !last_o) |=> (result_valid_o && $stable(digit_count_o)))
    else $error("digit run broken before its last digit");
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (digit_count_o != '0 && digit_count_o <= COUNT_W'(LIMIT)))
    else $error("digit count out of range");
  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> (state_q == BACK_IDLE && !q_status_i.empty))
    else $error("queue popped while emitting or empty");

endmodule

`default_nettype wire

// ----- hw/rtl/binary_to_decimal_digits_unit.sv -----
// ----------------------------------------------------------------------------
// binary_to_decimal_digits_unit
// Converts a 31-bit binary value into decimal digits, most significant first,
// with leading zeros suppressed.
// ----------------------------------------------------------------------------
// busy stays high per item through 31 shift-add-3 steps and the push state,
// and longer only while the two-entry queue is full.
// The first digit is strobed once the item is pushed into the queue and popped
// by the emitter, then one digit per cycle for digit_count digits; the receiver
// cannot stall. A new item is accepted only after the last one is pushed.
// Reset clears the control state and empties the queue; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module binary_to_decimal_digits_unit #(
  parameter int MAX_DIGITS  = bcdd_pkg::MAX_DIGITS_DEF,
  parameter int QUEUE_DEPTH = bcdd_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [bcdd_pkg::VALUE_W-1:0]  value_i,
  output logic                               result_valid_o,
  output logic [bcdd_pkg::DIGIT_W-1:0]       digit_o,
  output logic [bcdd_pkg::COUNT_W-1:0]       digit_count_o,
  output logic                               last_o
);
  import bcdd_pkg::*;

  localparam int LIMIT   = (MAX_DIGITS < HW_DIGITS) ? MAX_DIGITS : HW_DIGITS;
  localparam int BCD_W   = LIMIT * DIGIT_W;
  localparam int ENTRY_W = COUNT_W + BCD_W;

  q_status_t          q_status;
  logic               push, pop;
  logic [COUNT_W-1:0] push_count;
  logic [BCD_W-1:0]   push_bcd;
  logic [ENTRY_W-1:0] q_dout;

  bcdd_front #(
    .LIMIT(LIMIT)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .value_i     (value_i),
    .q_status_i  (q_status),
    .push_o      (push),
    .push_count_o(push_count),
    .push_bcd_o  (push_bcd)
  );

  bcdd_queue #(
    .WIDTH(ENTRY_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .din_i   ({push_count, push_bcd}),
    .pop_i   (pop),
    .dout_o  (q_dout),
    .status_o(q_status)
  );

  bcdd_back #(
    .LIMIT(LIMIT)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_status_i    (q_status),
    .q_count_i     (q_dout[ENTRY_W-1 -: COUNT_W]),
    .q_bcd_i       (q_dout[BCD_W-1:0]),
    .pop_o         (pop),
    .result_valid_o(result_valid_o),
    .digit_o       (digit_o),
    .digit_count_o (digit_count_o),
    .last_o        (last_o)
  );

endmodule

`default_nettype wire

// ----- test/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for binary_to_decimal_digits_unit. A directed table
// covers zero, single digits, powers of ten and the 31-bit maximum. Random
// values of every digit length follow. Each accepted value is expanded into
// its expected digit run, and each strobed digit is compared in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

  import bcdd_pkg::*;

  localparam int  DIGITS_KEPT  = MAX_DIGITS_DEF;
  localparam int  RANDOM_ITEMS = 300;
  localparam int  GAP_PERCENT  = 18;
  localparam int  DRAIN_CYCLES = 50;
  localparam int  DRAIN_LIMIT  = 5000;
  localparam logic [VALUE_W-1:0] VALUE_MAX = '1;

  typedef struct packed {
    logic [DIGIT_W-1:0] digit;
    logic [COUNT_W-1:0] count;
    logic               last;
  } digit_result_t;

  // Empty digit string: the run comes from the predictor.
  typedef struct {
    logic [VALUE_W-1:0] value;
    string              digits;
  } stim_row_t;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               start;
  logic               busy;
  logic [VALUE_W-1:0] value_i;
  logic               result_valid_o;
  logic [DIGIT_W-1:0] digit_o;
  logic [COUNT_W-1:0] digit_count_o;
  logic               last_o;

  digit_result_t pending_digits[$];
  int            errors         = 0;
  int            items_sent     = 0;
  int            digits_checked = 0;
  int            runs_by_len[1:HW_DIGITS];

  stim_row_t directed_rows[] = '{
    '{31'd0,          "0"},
    '{31'd1,          "1"},
    '{31'd9,          "9"},
    '{31'd10,         "10"},
    '{31'd99,         "99"},
    '{31'd100,        "100"},
    '{31'd7,          "7"},
    '{31'd0,          "0"},
    '{31'd12345,      "12345"},
    '{31'd1000,       ""},
    '{31'd9999,       ""},
    '{31'd65535,      ""},
    '{31'd100000000,  ""},
    '{31'd999999999,  "999999999"},
    '{31'd1000000000, "1000000000"},
    '{31'd1999999999, ""},
    '{31'd2000000000, "2000000000"},
    '{31'd2147483647, "2147483647"},
    '{31'h40000000,   ""},
    '{31'h55555555,   ""},
    '{31'h2AAAAAAA,   ""},
    '{31'd5,          "5"}
  };

  binary_to_decimal_digits_unit #(
    .MAX_DIGITS(DIGITS_KEPT)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .value_i       (value_i),
    .result_valid_o(result_valid_o),
    .digit_o       (digit_o),
    .digit_count_o (digit_count_o),
    .last_o        (last_o)
  );

  always #5 clk_i = ~clk_i;

  // Queue the digit run of one accepted value, most significant digit first.
  function automatic void queue_digit_run(input logic [VALUE_W-1:0] value,
                                          input string typed);
    logic [DIGIT_W-1:0] held[HW_DIGITS];
    logic [VALUE_W-1:0] rest;
    digit_result_t      entry;
    int                 n;
    int                 keep;
    if (typed.len() > 0) begin
      for (int i = 0; i < typed.len(); i++) begin
        entry.digit = DIGIT_W'(typed[i] - 8'd48);
        entry.count = COUNT_W'(typed.len());
        entry.last  = (i == typed.len() - 1);
        pending_digits.push_back(entry);
      end
      return;
    end
    rest = value;
    n    = 0;
    do begin
      held[n] = DIGIT_W'(rest % 10);
      rest    = VALUE_W'(rest / 10);
      n++;
    end while (rest != 0 && n < HW_DIGITS);
    keep = (DIGITS_KEPT < HW_DIGITS) ? DIGITS_KEPT : HW_DIGITS;
    if (keep < 1) keep = 1;
    if (n > keep) n = keep;
    for (int k = 0; k < n; k++) begin
      entry.digit = held[n - 1 - k];
      entry.count = COUNT_W'(n);
      entry.last  = (k == n - 1);
      pending_digits.push_back(entry);
    end
  endfunction

  // Present one value and hold start until busy is seen low at an edge.
  // With gaps allowed, start drops while busy and each ready cycle idles
  // at random before the item goes out.
  task automatic convert_value(input logic [VALUE_W-1:0] value, input string typed,
                               input bit allow_gap);
    @(negedge clk_i);
    if (allow_gap) begin
      while (busy || $urandom_range(0, 99) < GAP_PERCENT) begin
        start   <= 1'b0;
        value_i <= VALUE_W'($urandom());
        @(negedge clk_i);
      end
    end
    start   <= 1'b1;
    value_i <= value;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    queue_digit_run(value, typed);
    items_sent++;
  endtask

  always @(posedge clk_i) begin : check_digits
    digit_result_t want;
    if (rst_ni && result_valid_o) begin
      if (pending_digits.size() == 0) begin
        errors++;
        $display("%0t: unexpected digit %0d count %0d last %0b", $time,
                 digit_o, digit_count_o, last_o);
      end else begin
        want = pending_digits.pop_front();
        digits_checked++;
        if (last_o && digit_count_o >= 1 && digit_count_o <= HW_DIGITS)
          runs_by_len[digit_count_o]++;
        if (digit_o !== want.digit) begin
          errors++;
          $display("%0t: digit expected %0d actual %0d", $time, want.digit, digit_o);
        end
        if (digit_count_o !== want.count) begin
          errors++;
          $display("%0t: digit_count expected %0d actual %0d", $time,
                   want.count, digit_count_o);
        end
        if (last_o !== want.last) begin
          errors++;
          $display("%0t: last expected %0b actual %0b", $time, want.last, last_o);
        end
      end
    end
  end

  initial begin
    #2000000;
    $display("timeout at %0t with %0d digits outstanding", $time, pending_digits.size());
    $display("binary_to_decimal_digits_unit: mismatch");
    $finish;
  end

  initial begin
    longint unsigned pow10;
    longint unsigned lo;
    longint unsigned hi;
    logic [VALUE_W-1:0] pick;
    int kind;
    int len;
    int waited;
    foreach (runs_by_len[i]) runs_by_len[i] = 0;
    rst_ni  = 1'b0;
    start   = 1'b0;
    value_i = '0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Back to back, with no idle gaps between items.
    foreach (directed_rows[i])
      convert_value(directed_rows[i].value, directed_rows[i].digits, 1'b0);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      kind = $urandom_range(0, 9);
      if (kind <= 5) begin
        // Uniform over digit length, then over the values of that length.
        len   = $urandom_range(1, HW_DIGITS);
        pow10 = 1;
        for (int j = 1; j < len; j++) pow10 = pow10 * 10;
        lo = (len == 1) ? 0 : pow10;
        hi = (len == HW_DIGITS) ? longint'(VALUE_MAX) : pow10 * 10 - 1;
        pick = VALUE_W'($urandom_range(int'(hi), int'(lo)));
      end else if (kind == 6) begin
        // Powers of ten and the all-nines value just below.
        len   = $urandom_range(1, HW_DIGITS - 1);
        pow10 = 1;
        for (int j = 0; j < len; j++) pow10 = pow10 * 10;
        pick = VALUE_W'(pow10 - $urandom_range(0, 1));
      end else if (kind <= 8) begin
        pick = VALUE_W'($urandom());
      end else begin
        pick = VALUE_W'($urandom_range(0, 20));
      end
      // Middle third runs with no gaps at all.
      convert_value(pick, "", !(n >= 100 && n < 200));
    end
    @(negedge clk_i);
    start <= 1'b0;

    waited = 0;
    while (pending_digits.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (pending_digits.size() != 0) begin
      errors++;
      $display("%0t: %0d expected digits never arrived", $time, pending_digits.size());
    end

    $display("converted %0d values into %0d checked digits", items_sent, digits_checked);
    $display("runs by length 1..10: %0d %0d %0d %0d %0d %0d %0d %0d %0d %0d",
             runs_by_len[1], runs_by_len[2], runs_by_len[3], runs_by_len[4],
             runs_by_len[5], runs_by_len[6], runs_by_len[7], runs_by_len[8],
             runs_by_len[9], runs_by_len[10]);
    if (errors == 0) begin
      $display("binary_to_decimal_digits_unit: match");
    end else begin
      $display("binary_to_decimal_digits_unit: mismatch");
    end
    $finish;
  end

endmodule
